@@ hw/rtl/torch_warmup_burn_sequencer_top_macros.svh @@
// ----------------------------------------------------------------------------
// Torch sequencer assertion macros
// Shared wrappers for the concurrent checks on the top level ports.
// ----------------------------------------------------------------------------
`ifndef TORCH_WARMUP_BURN_SEQUENCER_TOP_MACROS_SVH
`define TORCH_WARMUP_BURN_SEQUENCER_TOP_MACROS_SVH

// Check that is skipped while reset is held.
`define TWBS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that is evaluated during reset too.
`define TWBS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/twbs_pkg.sv @@
// ----------------------------------------------------------------------------
// Torch sequencer package
// Types, codes and reset constants shared by the sequencer modules.
// ----------------------------------------------------------------------------
package twbs_pkg;

    localparam int MS_PER_SECOND_DEF = 1000;
    localparam int COUNTER_BITS_DEF  = 20;

    localparam int WARM_BITS      = 10;
    localparam int BURN_BITS      = 8;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 10;

    localparam int WARM_SETTING_RESET = 140;
    localparam int BURN_SETTING_RESET = 10;
    localparam int TENTHS_PER_UNIT    = 10;

    localparam logic [WARM_BITS-1:0] WARM_MIN_RESET = 10'd1;
    localparam logic [WARM_BITS-1:0] WARM_MAX_RESET = 10'd300;
    localparam logic [BURN_BITS-1:0] BURN_MIN_RESET = 8'd1;
    localparam logic [BURN_BITS-1:0] BURN_MAX_RESET = 8'd100;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WARM_MIN = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WARM_MAX = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BURN_MIN = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BURN_MAX = 2'd3;

    localparam logic [1:0] KNOB_DEC = 2'd1;
    localparam logic [1:0] KNOB_INC = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WARM = 2'd1,
        PH_BURN = 2'd2
    } phase_t;

    typedef struct packed {
        logic       ms_tick;
        logic       torch_request;
        logic       manual_hold;
        logic       estop_pressed;
        logic [1:0] warm_knob;
        logic [1:0] burn_knob;
    } item_t;

    typedef struct packed {
        logic                 relay_drive;
        logic                 arc_ok;
        logic                 estop_flag;
        phase_t               phase;
        logic [WARM_BITS-1:0] warm_seconds_now;
        logic [BURN_BITS-1:0] burn_tenths_now;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } result_req_t;

endpackage

@@ hw/rtl/torch_warmup_burn_sequencer_top.sv @@
// Results go through the input register, then the result queue. Throughput:
// one request per cycle while the queue has room; the input register feeds
// a single pass of compare and add logic straight into a two-entry result
// queue. The queue lets requests keep flowing while one result waits to be
// taken. Reset (aresetn low, synchronous) idles the sequence, clears the
// counter, empties the queue and loads the default settings and limits.
// ----------------------------------------------------------------------------
// Torch warm-up and burn sequencer
// Steps the warm and burn phases, relay and arc-ok from control loop passes.
// ----------------------------------------------------------------------------
module torch_warmup_burn_sequencer_top #(
    parameter int MS_PER_SECOND = twbs_pkg::MS_PER_SECOND_DEF,
    parameter int COUNTER_BITS  = twbs_pkg::COUNTER_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [twbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [twbs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_ms_tick,
    input  logic                                s_torch_request,
    input  logic                                s_manual_hold,
    input  logic                                s_estop_pressed,
    input  logic [1:0]                          s_warm_knob,
    input  logic [1:0]                          s_burn_knob,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_relay_drive,
    output logic                                m_arc_ok,
    output logic                                m_estop_flag,
    output logic [1:0]                          m_phase,
    output logic [twbs_pkg::WARM_BITS-1:0]      m_warm_seconds_now,
    output logic [twbs_pkg::BURN_BITS-1:0]      m_burn_tenths_now
);

    twbs_pkg::item_t       s_item;
    twbs_pkg::result_req_t q_push;
    twbs_pkg::result_t     m_data;
    logic                  q_room;

    always_comb begin
        s_item.ms_tick       = s_ms_tick;
        s_item.torch_request = s_torch_request;
        s_item.manual_hold   = s_manual_hold;
        s_item.estop_pressed = s_estop_pressed;
        s_item.warm_knob     = s_warm_knob;
        s_item.burn_knob     = s_burn_knob;
    end

    twbs_core #(
        .MS_PER_SECOND (MS_PER_SECOND),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .q_room    (q_room),
        .q_push    (q_push)
    );

    twbs_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .room    (q_room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    assign m_relay_drive      = m_data.relay_drive;
    assign m_arc_ok           = m_data.arc_ok;
    assign m_estop_flag       = m_data.estop_flag;
    assign m_phase            = m_data.phase;
    assign m_warm_seconds_now = m_data.warm_seconds_now;
    assign m_burn_tenths_now  = m_data.burn_tenths_now;

endmodule

@@ hw/rtl/twbs_core.sv @@
// ----------------------------------------------------------------------------
// Torch sequencer core
// Input register, configuration registers, sequence state and the per-pass
// update that produces one result request for each item.
// ----------------------------------------------------------------------------
module twbs_core #(
    parameter int MS_PER_SECOND = twbs_pkg::MS_PER_SECOND_DEF,
    parameter int COUNTER_BITS  = twbs_pkg::COUNTER_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [twbs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [twbs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  twbs_pkg::item_t                     s_item,
    input  logic                                q_room,
    output twbs_pkg::result_req_t               q_push
);

    localparam int MS_BITS  = $clog2(MS_PER_SECOND + 1);
    localparam int WPB      = twbs_pkg::WARM_BITS + MS_BITS;
    localparam int BPB      = twbs_pkg::BURN_BITS + MS_BITS;
    localparam int EXB      = COUNTER_BITS + 4;
    localparam int CW0      = (WPB > BPB) ? WPB : BPB;
    localparam int CW       = (CW0 > EXB) ? CW0 : EXB;

    localparam logic [WPB-1:0] WARM_STEP = WPB'(MS_PER_SECOND);
    localparam logic [BPB-1:0] BURN_STEP = BPB'(MS_PER_SECOND);
    localparam logic [WPB-1:0] WARM_MS_RESET =
        WPB'(longint'(twbs_pkg::WARM_SETTING_RESET) * longint'(MS_PER_SECOND));
    localparam logic [BPB-1:0] BURN_MS_RESET =
        BPB'(longint'(twbs_pkg::BURN_SETTING_RESET) * longint'(MS_PER_SECOND));

    logic                           in_valid_reg;
    twbs_pkg::item_t                in_item_reg;
    logic                           advance;

    logic [twbs_pkg::WARM_BITS-1:0] warm_min_reg, warm_max_reg;
    logic [twbs_pkg::BURN_BITS-1:0] burn_min_reg, burn_max_reg;

    twbs_pkg::phase_t               phase_reg, phase_next;
    logic [COUNTER_BITS-1:0]        elapsed_reg, elapsed_next, elapsed_tick;
    logic                           relay_reg, relay_next;
    logic                           arc_reg, arc_next;
    logic                           stop_next;
    logic [twbs_pkg::WARM_BITS-1:0] warm_reg, warm_next;
    logic [twbs_pkg::BURN_BITS-1:0] burn_reg, burn_next;
    logic [WPB-1:0]                 warm_ms_reg, warm_ms_next;
    logic [BPB-1:0]                 burn_ms_reg, burn_ms_next;

    logic [EXB-1:0]                 elapsed_x10;
    logic                           warm_due, burn_due, restarted;

    assign advance = in_valid_reg && q_room;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warm_min_reg <= twbs_pkg::WARM_MIN_RESET;
            warm_max_reg <= twbs_pkg::WARM_MAX_RESET;
            burn_min_reg <= twbs_pkg::BURN_MIN_RESET;
            burn_max_reg <= twbs_pkg::BURN_MAX_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                twbs_pkg::CFG_WARM_MIN: begin
                    warm_min_reg <= cfg_wdata[twbs_pkg::WARM_BITS-1:0];
                end
                twbs_pkg::CFG_WARM_MAX: begin
                    warm_max_reg <= cfg_wdata[twbs_pkg::WARM_BITS-1:0];
                end
                twbs_pkg::CFG_BURN_MIN: begin
                    burn_min_reg <= cfg_wdata[twbs_pkg::BURN_BITS-1:0];
                end
                twbs_pkg::CFG_BURN_MAX: begin
                    burn_max_reg <= cfg_wdata[twbs_pkg::BURN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= twbs_pkg::PH_IDLE;
            elapsed_reg <= '0;
            relay_reg   <= 1'b0;
            arc_reg     <= 1'b0;
            warm_reg    <= twbs_pkg::WARM_BITS'(twbs_pkg::WARM_SETTING_RESET);
            burn_reg    <= twbs_pkg::BURN_BITS'(twbs_pkg::BURN_SETTING_RESET);
            warm_ms_reg <= WARM_MS_RESET;
            burn_ms_reg <= BURN_MS_RESET;
        end else if (advance) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            relay_reg   <= relay_next;
            arc_reg     <= arc_next;
            warm_reg    <= warm_next;
            burn_reg    <= burn_next;
            warm_ms_reg <= warm_ms_next;
            burn_ms_reg <= burn_ms_next;
        end
    end

    // The delays in milliseconds are tracked next to the settings, so a knob
    // step only adds or subtracts one second's worth of milliseconds.
    always_comb begin
        warm_next    = warm_reg;
        warm_ms_next = warm_ms_reg;
        if (in_item_reg.warm_knob == twbs_pkg::KNOB_DEC && warm_reg > warm_min_reg) begin
            warm_next    = warm_reg - 1'b1;
            warm_ms_next = warm_ms_reg - WARM_STEP;
        end else if (in_item_reg.warm_knob == twbs_pkg::KNOB_INC &&
                     warm_reg < warm_max_reg) begin
            warm_next    = warm_reg + 1'b1;
            warm_ms_next = warm_ms_reg + WARM_STEP;
        end

        burn_next    = burn_reg;
        burn_ms_next = burn_ms_reg;
        if (in_item_reg.burn_knob == twbs_pkg::KNOB_DEC && burn_reg > burn_min_reg) begin
            burn_next    = burn_reg - 1'b1;
            burn_ms_next = burn_ms_reg - BURN_STEP;
        end else if (in_item_reg.burn_knob == twbs_pkg::KNOB_INC &&
                     burn_reg < burn_max_reg) begin
            burn_next    = burn_reg + 1'b1;
            burn_ms_next = burn_ms_reg + BURN_STEP;
        end
    end

    always_comb begin
        elapsed_tick = elapsed_reg;
        if (in_item_reg.ms_tick && elapsed_reg != '1) begin
            elapsed_tick = elapsed_reg + 1'b1;
        end
        elapsed_x10 = (EXB'(elapsed_tick) << 3) + (EXB'(elapsed_tick) << 1);
        warm_due    = CW'(elapsed_tick) > CW'(warm_ms_next);
        burn_due    = CW'(elapsed_x10) > CW'(burn_ms_next);
    end

    // A phase entered in this pass starts from a cleared count, which can
    // never be past either delay, so the due flags are masked by restarted.
    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_tick;
        relay_next   = relay_reg;
        arc_next     = arc_reg;
        stop_next    = in_item_reg.estop_pressed;
        restarted    = 1'b0;
        if (in_item_reg.torch_request) begin
            if (phase_next == twbs_pkg::PH_IDLE && !arc_reg) begin
                phase_next = twbs_pkg::PH_WARM;
                restarted  = 1'b1;
            end
            if (in_item_reg.estop_pressed && phase_next == twbs_pkg::PH_WARM) begin
                phase_next = twbs_pkg::PH_BURN;
                relay_next = 1'b1;
                restarted  = 1'b1;
            end
            if (phase_next == twbs_pkg::PH_WARM && !in_item_reg.manual_hold &&
                !restarted && warm_due) begin
                phase_next = twbs_pkg::PH_BURN;
                relay_next = 1'b1;
                restarted  = 1'b1;
            end
            if (phase_next == twbs_pkg::PH_BURN && !restarted && burn_due) begin
                phase_next = twbs_pkg::PH_IDLE;
                arc_next   = 1'b1;
            end
            if (restarted) begin
                elapsed_next = '0;
            end
        end else begin
            phase_next = twbs_pkg::PH_IDLE;
            relay_next = 1'b0;
            arc_next   = 1'b0;
        end
    end

    always_comb begin
        q_push.valid                 = advance;
        q_push.data.relay_drive      = relay_next;
        q_push.data.arc_ok           = arc_next;
        q_push.data.estop_flag       = stop_next;
        q_push.data.phase            = phase_next;
        q_push.data.warm_seconds_now = warm_next;
        q_push.data.burn_tenths_now  = burn_next;
    end

endmodule

@@ hw/rtl/twbs_outq.sv @@
// ----------------------------------------------------------------------------
// Torch sequencer result queue
// Two-entry output buffer that keeps the core running while a result waits.
// ----------------------------------------------------------------------------
module twbs_outq (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  twbs_pkg::result_req_t push,
    output logic                  room,
    output logic                  m_valid,
    input  logic                  m_ready,
    output twbs_pkg::result_t     m_data
);

    localparam logic [1:0] DEPTH = 2'd2;

    logic [1:0]        count_reg, count_next;
    twbs_pkg::result_t ent_reg  [2];
    twbs_pkg::result_t ent_next [2];
    logic              pop;
    logic              wr_pos;

    assign m_valid = count_reg != 2'd0;
    assign m_data  = ent_reg[0];
    assign pop     = m_valid && m_ready;
    assign room    = count_reg != DEPTH || m_ready;
    assign wr_pos  = 1'(count_reg - 2'(pop));

    always_comb begin
        count_next  = count_reg - 2'(pop) + 2'(push.valid);
        ent_next[0] = ent_reg[0];
        ent_next[1] = ent_reg[1];
        if (pop) begin
            ent_next[0] = ent_reg[1];
        end
        if (push.valid) begin
            ent_next[wr_pos] = push.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg[0] <= ent_next[0];
        ent_reg[1] <= ent_next[1];
    end

endmodule

@@ hw/rtl/twbs_checker.sv @@
// ----------------------------------------------------------------------------
// Torch sequencer checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "torch_warmup_burn_sequencer_top_macros.svh"

module twbs_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic                                m_relay_drive,
    input logic                                m_arc_ok,
    input logic                                m_estop_flag,
    input logic [1:0]                          m_phase,
    input logic [twbs_pkg::WARM_BITS-1:0]      m_warm_seconds_now,
    input logic [twbs_pkg::BURN_BITS-1:0]      m_burn_tenths_now
);

    `TWBS_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid,
        "result offered right after reset")

    `TWBS_ASSERT(a_arc_needs_relay, m_valid && m_arc_ok |-> m_relay_drive,
        "arc-ok reported with the relay open")

    `TWBS_ASSERT(a_burn_relay, m_valid && m_phase == twbs_pkg::PH_BURN |-> m_relay_drive,
        "burn phase reported with the relay open")

    `TWBS_ASSERT(a_arc_not_warming, m_valid && m_arc_ok |-> m_phase != twbs_pkg::PH_WARM,
        "arc-ok reported during the warm phase")

    `TWBS_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid &&
        $stable({m_relay_drive, m_arc_ok, m_estop_flag, m_phase,
                 m_warm_seconds_now, m_burn_tenths_now}),
        "stalled result dropped or changed")

endmodule

bind torch_warmup_burn_sequencer_top twbs_checker u_twbs_checker (.*);
